// File: hdl/vwt_pkg.sv
`timescale 1ns / 1ps

package vwt_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned EPS_W    = 16;
  localparam int unsigned INDEX_W  = 10;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd6;

  localparam logic CMD_EXACT = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               inserted;
    logic               full_res;
  } res_t;

endpackage

// File: hdl/vwt_ram.sv
`timescale 1ns / 1ps

module vwt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vwt_cmp.sv
`timescale 1ns / 1ps

module vwt_cmp (
  input  vwt_pkg::req_t                      req_i,
  input  logic signed [vwt_pkg::COORD_W-1:0] sx_i,
  input  logic signed [vwt_pkg::COORD_W-1:0] sy_i,
  input  logic [vwt_pkg::EPS_W-1:0]          eps_i,
  output logic                               match_o
);

  localparam int unsigned DW = vwt_pkg::COORD_W + 1;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic [DW-1:0]        eps_ext;
  logic                 exact;

  always_comb begin
    dx      = {sx_i[vwt_pkg::COORD_W-1], sx_i} - {req_i.x[vwt_pkg::COORD_W-1], req_i.x};
    dy      = {sy_i[vwt_pkg::COORD_W-1], sy_i} - {req_i.y[vwt_pkg::COORD_W-1], req_i.y};
    adx     = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady     = dy[DW-1] ? DW'(-dy) : DW'(dy);
    eps_ext = DW'(eps_i);
    exact   = (req_i.cmd == vwt_pkg::CMD_EXACT) || (eps_i <= vwt_pkg::EPS_W'(1));
    if (exact) begin
      match_o = (sx_i == req_i.x) && (sy_i == req_i.y);
    end else begin
      match_o = (adx < eps_ext) && (ady < eps_ext);
    end
  end

endmodule

// File: hdl/vertex_weld_table.sv
`timescale 1ns / 1ps

// A lookup that matches stored entry k delivers its result with index k and ends the scan there.
// A lookup that checks all n stored entries without a match delivers an insert or full result.
// One RAM read port and one comparator check one entry per cycle; start is taken again
// in the cycle the result strobe is high. The receiver cannot stall the result.
// Reset clears the entry count and sets epsilon to 6; stored vertices are not cleared.

module vertex_weld_table #(
  parameter int unsigned CAPACITY = vwt_pkg::CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  vwt_pkg::req_t              req_i,
  output logic                       valid_o,
  output vwt_pkg::res_t              res_o,
  input  logic                       cfg_we_i,
  input  logic [vwt_pkg::EPS_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = 2 * vwt_pkg::COORD_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                      state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             addr_q, addr_d;
  logic [AW-1:0]             rd_idx_q, rd_idx_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [vwt_pkg::EPS_W-1:0] eps_q;
  vwt_pkg::req_t             req_q, req_d;
  vwt_pkg::res_t             res_q, res_d;
  logic                      valid_q, valid_d;

  logic                      rd_en;
  logic                      wr_en;
  logic [WW-1:0]             rdata;
  logic                      match;

  vwt_ram #(
    .WIDTH (WW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({req_q.x, req_q.y}),
    .re_i    (rd_en),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  vwt_cmp u_cmp (
    .req_i   (req_q),
    .sx_i    (rdata[WW-1:vwt_pkg::COORD_W]),
    .sy_i    (rdata[vwt_pkg::COORD_W-1:0]),
    .eps_i   (eps_q),
    .match_o (match)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    addr_d   = addr_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    req_d    = req_q;
    res_d    = res_q;
    valid_d  = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          addr_d   = '0;
          rd_vld_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && match) begin
          res_d.index    = vwt_pkg::INDEX_W'(rd_idx_q);
          res_d.inserted = 1'b0;
          res_d.full_res = 1'b0;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end else if (addr_q < count_q) begin
          rd_en    = 1'b1;
          rd_idx_d = addr_q[AW-1:0];
          rd_vld_d = 1'b1;
          addr_d   = addr_q + CW'(1);
        end else if (count_q < CW'(CAPACITY)) begin
          wr_en          = 1'b1;
          count_d        = count_q + CW'(1);
          res_d.index    = vwt_pkg::INDEX_W'(count_q[AW-1:0]);
          res_d.inserted = 1'b1;
          res_d.full_res = 1'b0;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          res_d.index    = '0;
          res_d.inserted = 1'b0;
          res_d.full_res = 1'b1;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
      eps_q    <= vwt_pkg::EPS_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      addr_q   <= addr_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    req_q    <= req_d;
    res_q    <= res_d;
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while still scanning");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.inserted) |-> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("insert result without entry count step");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(res_o.inserted && res_o.full_res))
    else $error("inserted and full flags both set");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  vwt_pkg::req_t             req_i;
  logic                      valid_o;
  vwt_pkg::res_t             res_o;
  logic                      cfg_we_i;
  logic [vwt_pkg::EPS_W-1:0] cfg_wdata_i;

  vertex_weld_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .valid_o     (valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [vwt_pkg::COORD_W-1:0] vertex_x [vwt_pkg::CAPACITY];
  logic [vwt_pkg::COORD_W-1:0] vertex_y [vwt_pkg::CAPACITY];
  int unsigned                 vertex_count;
  logic [vwt_pkg::EPS_W-1:0]   eps_shadow;
  vwt_pkg::res_t               pending_res [$];
  int unsigned                 err_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(64_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic vwt_pkg::req_t mk_req(input logic cmd,
                                           input logic [vwt_pkg::COORD_W-1:0] x,
                                           input logic [vwt_pkg::COORD_W-1:0] y);
    vwt_pkg::req_t r;
    r.cmd = cmd;
    r.x   = x;
    r.y   = y;
    return r;
  endfunction

  function automatic bit vertex_matches(input int unsigned k, input vwt_pkg::req_t r);
    longint dx, dy;
    if (r.cmd == vwt_pkg::CMD_EXACT || eps_shadow <= 1) begin
      return vertex_x[k] == r.x && vertex_y[k] == r.y;
    end
    dx = longint'($signed(vertex_x[k])) - longint'($signed(r.x));
    dy = longint'($signed(vertex_y[k])) - longint'($signed(r.y));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx < longint'(eps_shadow) && dy < longint'(eps_shadow);
  endfunction

  // Searches the shadow table in index order and appends on a miss unless the table is full.
  function automatic vwt_pkg::res_t find_or_insert(input vwt_pkg::req_t r);
    vwt_pkg::res_t res;
    int unsigned k;
    res = '0;
    for (k = 0; k < vertex_count; k++) begin
      if (vertex_matches(k, r)) begin
        res.index = k[vwt_pkg::INDEX_W-1:0];
        return res;
      end
    end
    if (vertex_count >= vwt_pkg::CAPACITY) begin
      res.full_res = 1'b1;
      return res;
    end
    vertex_x[vertex_count] = r.x;
    vertex_y[vertex_count] = r.y;
    res.index    = vertex_count[vwt_pkg::INDEX_W-1:0];
    res.inserted = 1'b1;
    vertex_count++;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_res.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        if (res_o.index !== pending_res[0].index)
          report_mismatch($sformatf("index %0d, want %0d", res_o.index,
                                    pending_res[0].index));
        if (res_o.inserted !== pending_res[0].inserted)
          report_mismatch($sformatf("inserted %b, want %b", res_o.inserted,
                                    pending_res[0].inserted));
        if (res_o.full_res !== pending_res[0].full_res)
          report_mismatch($sformatf("full_res %b, want %b", res_o.full_res,
                                    pending_res[0].full_res));
        void'(pending_res.pop_front());
      end
    end
  end

  task automatic push_vertex(input vwt_pkg::req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    pending_res.push_back(find_or_insert(r));
  endtask

  task automatic idle_burst(input bit allow);
    if (allow && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (busy_o);
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_epsilon(input logic [vwt_pkg::EPS_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eps_shadow = value;
  endtask

  task automatic test_exact_and_extremes;
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'h0000_0000, 32'h0000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'h0000_0000, 32'h0000_0000));
    idle_burst(1'b1);
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'h7FFF_FFFF, 32'h8000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'h8000_0000, 32'h7FFF_FFFF));
    idle_burst(1'b1);
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0005, 32'hFFFF_FFFB));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0006, 32'h0000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h7FFF_FFFA, 32'h8000_0005));
    push_vertex(mk_req(vwt_pkg::CMD_EXACT, 32'hAAAA_5555, 32'h5555_AAAA));
  endtask

  task automatic test_epsilon_edges;
    drain;
    write_epsilon(16'd1);
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0001, 32'h0000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0000, 32'h0000_0000));
    drain;
    write_epsilon(16'd0);
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0006, 32'h0000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0007, 32'h0000_0000));
    drain;
    write_epsilon(16'd2);
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0001, 32'hFFFF_FFFF));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_0008, 32'h0000_0001));
    drain;
    write_epsilon(16'hFFFF);
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0000_FFFE, 32'h0000_0000));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h8000_0001, 32'h7FFF_FFFE));
    push_vertex(mk_req(vwt_pkg::CMD_CLOSE, 32'h0001_0000, 32'h0000_0000));
  endtask

  task automatic test_random_mix;
    logic [vwt_pkg::EPS_W-1:0] eps_plan [6];
    logic [vwt_pkg::COORD_W-1:0] extremes [8];
    logic [vwt_pkg::COORD_W-1:0] off_x, off_y;
    vwt_pkg::req_t r;
    int unsigned k;
    int p, n;
    eps_plan[0] = 16'd0;
    eps_plan[1] = 16'($urandom_range(2, 64));
    eps_plan[2] = 16'hFFFF;
    eps_plan[3] = 16'd1;
    eps_plan[4] = 16'($urandom_range(2, 16'hFFFF));
    eps_plan[5] = 16'd2;
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0001_0000};
    for (p = 0; p < 6; p++) begin
      drain;
      write_epsilon(eps_plan[p]);
      for (n = 0; n < 95; n++) begin
        k = $urandom_range(0, vertex_count - 1);
        off_x = $urandom_range(0, int'(eps_shadow) + 1);
        off_y = $urandom_range(0, int'(eps_shadow) + 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r = mk_req(1'($urandom_range(0, 1)), vertex_x[k], vertex_y[k]);
          4, 5: r = mk_req(vwt_pkg::CMD_CLOSE,
                           $urandom_range(0, 1) ? vertex_x[k] + off_x : vertex_x[k] - off_x,
                           $urandom_range(0, 1) ? vertex_y[k] + off_y : vertex_y[k] - off_y);
          6, 7, 8: r = mk_req(1'($urandom_range(0, 1)), $urandom, $urandom);
          default: r = mk_req(1'($urandom_range(0, 1)), extremes[$urandom_range(0, 7)],
                              extremes[$urandom_range(0, 7)]);
        endcase
        push_vertex(r);
        idle_burst(p < 4);
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    req_i        <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    vertex_count = 0;
    eps_shadow   = vwt_pkg::EPS_RESET;
    err_count    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_exact_and_extremes;
    test_epsilon_edges;
    test_random_mix;

    start_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
